@@ src/sau_pkg.sv @@
package sau_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int DEPTH_OUT_W = 7;
  localparam int MIN_OPERANDS = 2;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_NOP  = 3'd5
  } cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] top_word;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
  } res_t;

  // Micro-operations driven into the datapath
  typedef enum logic [3:0] {
    A_NONE,
    A_PUSH,
    A_LD_SEC,
    A_ALU,
    A_DIV_INIT,
    A_DIV_STEP,
    A_DIV_FIN,
    A_SET_SHORT,
    A_SET_DZ,
    A_SET_FULL,
    A_EMIT
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_FULL,
    C_SHORT,
    C_IS_DIV,
    C_ZERO,
    C_MORE
  } cond_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Program addresses
  localparam upc_t U_PUSH_CHK  = 4'd0;
  localparam upc_t U_PUSH_DO   = 4'd1;
  localparam upc_t U_BIN_CHK   = 4'd2;
  localparam upc_t U_BIN_LD    = 4'd3;
  localparam upc_t U_ALU       = 4'd4;
  localparam upc_t U_DIV_CHK   = 4'd5;
  localparam upc_t U_DIV_STEP  = 4'd6;
  localparam upc_t U_DIV_END   = 4'd7;
  localparam upc_t U_SET_SHORT = 4'd8;
  localparam upc_t U_SET_DZ    = 4'd9;
  localparam upc_t U_SET_FULL  = 4'd10;
  localparam upc_t U_EMIT      = 4'd11;

  // Control store: jump to target when cond holds, else step on
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    w = '{act: A_EMIT, cond: C_NEVER, target: U_EMIT};
    unique case (addr)
      U_PUSH_CHK:  w = '{act: A_NONE,      cond: C_FULL,   target: U_SET_FULL};
      U_PUSH_DO:   w = '{act: A_PUSH,      cond: C_ALWAYS, target: U_EMIT};
      U_BIN_CHK:   w = '{act: A_NONE,      cond: C_SHORT,  target: U_SET_SHORT};
      U_BIN_LD:    w = '{act: A_LD_SEC,    cond: C_IS_DIV, target: U_DIV_CHK};
      U_ALU:       w = '{act: A_ALU,       cond: C_ALWAYS, target: U_EMIT};
      U_DIV_CHK:   w = '{act: A_DIV_INIT,  cond: C_ZERO,   target: U_SET_DZ};
      U_DIV_STEP:  w = '{act: A_DIV_STEP,  cond: C_MORE,   target: U_DIV_STEP};
      U_DIV_END:   w = '{act: A_DIV_FIN,   cond: C_ALWAYS, target: U_EMIT};
      U_SET_SHORT: w = '{act: A_SET_SHORT, cond: C_ALWAYS, target: U_EMIT};
      U_SET_DZ:    w = '{act: A_SET_DZ,    cond: C_ALWAYS, target: U_EMIT};
      U_SET_FULL:  w = '{act: A_SET_FULL,  cond: C_ALWAYS, target: U_EMIT};
      U_EMIT:      w = '{act: A_EMIT,      cond: C_NEVER,  target: U_EMIT};
      default:     w = '{act: A_EMIT,      cond: C_NEVER,  target: U_EMIT};
    endcase
    return w;
  endfunction

  // Entry point of the program for each command
  function automatic upc_t dispatch(input logic [2:0] command);
    upc_t a;
    unique case (command) inside
      CMD_PUSH:                   a = U_PUSH_CHK;
      CMD_ADD, CMD_SUB,
      CMD_DIV, CMD_MUL:           a = U_BIN_CHK;
      default:                    a = U_EMIT;
    endcase
    return a;
  endfunction

endpackage

@@ src/stack_arithmetic_unit.sv @@
// Channel   Ports                        Handshake
// request   start, busy, request         beat taken when start high and busy low
// result    done, result                 beat shown for one cycle while done high
//
// A microcoded sequencer runs each command; nop and spare codes go straight to the
// result, and div runs the 32 steps of a restoring divider. Busy drops as done
// rises, so a new beat can be taken in the result cycle. The top entry sits in a
// register, the rest in a RAM with registered read. Synchronous reset clears the
// count and the sequencer only. Results cannot stall.
module stack_arithmetic_unit
  import sau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

  logic                     running;
  upc_t                     upc;
  logic [CNT_W-1:0]         count;
  logic [WORD_W-1:0]        top;
  logic [WORD_W-1:0]        sec;
  logic [2:0]               cmd;
  logic [WORD_W-1:0]        pv;
  status_t                  status;
  logic [WORD_W-1:0]        rem;
  logic [WORD_W-1:0]        quo;
  logic [WORD_W-1:0]        den;
  logic                     neg;
  logic [4:0]               div_cnt;

  uword_t                   uw;
  logic                     jump;
  logic [WORD_W:0]          rem_sh;
  logic [WORD_W:0]          diff;
  logic [WORD_W-1:0]        alu_out;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic [CNT_W-1:0]         count_m1;
  logic [CNT_W-1:0]         count_m2;

  assign busy = running;
  assign uw   = ucode_rom(upc);

  // Evaluate the jump condition of the current control word
  always_comb begin
    case (uw.cond)
      C_ALWAYS: jump = 1'b1;
      C_FULL:   jump = (count == CNT_W'(STACK_DEPTH));
      C_SHORT:  jump = (count < CNT_W'(MIN_OPERANDS));
      C_IS_DIV: jump = (cmd == CMD_DIV);
      C_ZERO:   jump = (top == '0);
      C_MORE:   jump = (div_cnt != '1);
      default:  jump = 1'b0;
    endcase
  end

  // Stack addresses: write slot for the current top, and the entry below the top
  assign count_m1  = count - CNT_W'(1);
  assign count_m2  = count - CNT_W'(MIN_OPERANDS);
  assign ram_we    = running && (uw.act == A_PUSH) && (count != '0);
  assign ram_waddr = count_m1[ADDR_W-1:0];
  assign ram_raddr = count_m2[ADDR_W-1:0];

  sau_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Add, subtract or multiply second by top
  always_comb begin
    case (cmd)
      CMD_ADD: alu_out = sec + top;
      CMD_SUB: alu_out = sec - top;
      default: alu_out = sec * top;
    endcase
  end

  // One restoring divider step on magnitudes
  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      upc     <= U_EMIT;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (!running) begin
        if (start) begin
          running <= 1'b1;
          upc     <= dispatch(request.command);
        end
      end else begin
        if (uw.act == A_EMIT) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else if (jump) begin
          upc <= uw.target;
        end else begin
          upc <= upc + upc_t'(1);
        end
        if (uw.act == A_PUSH) begin
          count <= count + CNT_W'(1);
        end else if (uw.act == A_ALU || uw.act == A_DIV_FIN) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!running) begin
      if (start) begin
        cmd    <= request.command;
        pv     <= request.push_value;
        status <= ST_OK;
      end
    end else begin
      case (uw.act)
        A_PUSH:      top <= pv;
        A_LD_SEC:    sec <= ram_rdata;
        A_ALU:       top <= alu_out;
        A_DIV_INIT: begin
          rem     <= '0;
          quo     <= sec[WORD_W-1] ? (~sec + WORD_W'(1)) : sec;
          den     <= top[WORD_W-1] ? (~top + WORD_W'(1)) : top;
          neg     <= sec[WORD_W-1] ^ top[WORD_W-1];
          div_cnt <= '0;
        end
        A_DIV_STEP: begin
          div_cnt <= div_cnt + 5'd1;
          if (!diff[WORD_W]) begin
            rem <= diff[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b0};
          end
        end
        A_DIV_FIN:   top <= neg ? (~quo + WORD_W'(1)) : quo;
        A_SET_SHORT: status <= ST_SHORT;
        A_SET_DZ:    status <= ST_DIVZERO;
        A_SET_FULL:  status <= ST_FULL;
        default: ;
      endcase
    end
  end

  // Register the result beat alongside done
  always_ff @(posedge clk) begin
    if (running && uw.act == A_EMIT) begin
      result.status      <= status;
      result.top_word    <= (count != '0) ? top : '0;
      result.stack_depth <= DEPTH_OUT_W'(count);
    end
  end

endmodule

@@ src/sau_ram.sv @@
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/tb_stack_arithmetic_unit.sv @@
`timescale 1ns / 100ps

module tb_stack_arithmetic_unit;
  import sau_pkg::*;

  // Spare command codes; the block treats them as nop
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_BEATS = 1850;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 60;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // Shadow stack: predicts each result from the commands taken so far
  class stack_tracker;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int                count;
    res_t              pending_results [$];
    int                errors;
    int                taken;
    int                status_seen [4];

    function new();
      count  = 0;
      errors = 0;
      taken  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(input string what);
      $display("%0t ns  mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Apply one accepted command to the shadow stack and queue its result
    function void take_command(input req_t req);
      res_t              outcome;
      status_t           st;
      logic [WORD_W-1:0] top_w;
      logic [WORD_W-1:0] sec_w;
      logic [WORD_W-1:0] value;
      longint            quotient;
      bit                apply;
      st    = ST_OK;
      value = '0;
      apply = 1'b0;
      case (req.command) inside
        CMD_PUSH: begin
          if (count >= STACK_DEPTH) st = ST_FULL;
          else begin
            words[count] = req.push_value;
            count++;
          end
        end
        CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
          if (count < MIN_OPERANDS) st = ST_SHORT;
          else begin
            top_w = words[count-1];
            sec_w = words[count-2];
            apply = 1'b1;
            case (req.command)
              CMD_ADD: value = sec_w + top_w;
              CMD_SUB: value = sec_w - top_w;
              CMD_MUL: value = sec_w * top_w;
              default: begin
                if (top_w == '0) begin
                  st    = ST_DIVZERO;
                  apply = 1'b0;
                end else begin
                  // widen so the most negative word over minus one wraps cleanly
                  quotient = longint'($signed(sec_w)) / longint'($signed(top_w));
                  value    = quotient[WORD_W-1:0];
                end
              end
            endcase
            if (apply) begin
              words[count-2] = value;
              count--;
            end
          end
        end
        default: ;
      endcase
      outcome.status      = st;
      outcome.top_word    = (count != 0) ? words[count-1] : '0;
      outcome.stack_depth = DEPTH_OUT_W'(count);
      pending_results.push_back(outcome);
      taken++;
    endfunction

    // Compare one result beat with the oldest prediction
    task compare_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no command outstanding: %p", got));
      end else begin
        want = pending_results.pop_front();
        status_seen[got.status]++;
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.top_word !== want.top_word)
          report($sformatf("top_word %0d, expected %0d", got.top_word, want.top_word));
        if (got.stack_depth !== want.stack_depth)
          report($sformatf("stack_depth %0d, expected %0d",
                           got.stack_depth, want.stack_depth));
      end
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;

  stack_tracker track = new();

  int burst_left  = 0;
  bit gapless     = 1'b0;
  int sent        = 0;
  int quiet_count = 0;

  stack_arithmetic_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watch both channels; results are checked before a same-edge accept is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done) track.compare_result(result);
      if (start && !busy) track.take_command(request);
      if (done || (start && !busy)) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("tb_stack_arithmetic_unit: errors");
        $finish;
      end
    end
  end

  // Drive one command beat, opening a new burst after a random gap
  task automatic send(input logic [2:0] code, input logic signed [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gapless ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start   <= 1'b1;
    request <= '{command: code, push_value: word};
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (track.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    logic signed [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = 1;
      2:       w = -1;
      3:       w = WORD_MIN;
      4:       w = WORD_MAX;
      5, 6:    w = $signed($urandom_range(0, 20)) - 10;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] pick_command(input int push_pct);
    logic [2:0] c;
    if ($urandom_range(0, 99) < push_pct) return CMD_PUSH;
    case ($urandom_range(0, 19))
      0, 1, 2, 3:      c = CMD_ADD;
      4, 5, 6, 7:      c = CMD_SUB;
      8, 9, 10, 11, 12: c = CMD_DIV;
      13, 14, 15, 16:  c = CMD_MUL;
      17:              c = CMD_NOP;
      18:              c = CMD_SPARE_6;
      default:         c = CMD_SPARE_7;
    endcase
    return c;
  endfunction

  initial begin
    int seg_len;
    int push_pct;
    int seg_no;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short stack, wrapping, most negative over minus one, zero divisor
    send(CMD_ADD, '0);
    send(CMD_DIV, WORD_MAX);
    send(CMD_PUSH, WORD_MAX);
    send(CMD_MUL, '0);
    send(CMD_PUSH, 1);
    send(CMD_ADD, '0);
    send(CMD_PUSH, -1);
    send(CMD_DIV, '0);
    send(CMD_PUSH, '0);
    send(CMD_DIV, '0);
    send(CMD_SUB, '0);
    send(CMD_PUSH, WORD_MIN);
    send(CMD_SUB, '0);
    send(CMD_PUSH, WORD_MAX);
    send(CMD_PUSH, WORD_MAX);
    send(CMD_MUL, '0);
    send(CMD_NOP, WORD_MIN);
    send(CMD_SPARE_6, -1);
    send(CMD_SPARE_7, 32'sh5555_aaaa);
    send(CMD_PUSH, -7);
    send(CMD_PUSH, 2);
    send(CMD_DIV, '0);
    send(CMD_PUSH, 32'sh2aaa_5555);
    send(CMD_SUB, '0);
    wait_drained();

    // Random: segments lean towards filling or draining the stack
    seg_no = 0;
    while (sent < RANDOM_BEATS + 24) begin
      seg_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 30;
        default: push_pct = 55;
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      repeat (seg_len) send(pick_command(push_pct), pick_word());
      seg_no++;
      if (seg_no % 4 == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (track.pending() != 0)
      track.report($sformatf("%0d results never arrived", track.pending()));

    $display("ran %0d commands through push, arithmetic, nop and spare codes",
             track.taken);
    $display("status mix ok/short/divzero/full: %0d/%0d/%0d/%0d",
             track.status_seen[ST_OK], track.status_seen[ST_SHORT],
             track.status_seen[ST_DIVZERO], track.status_seen[ST_FULL]);
    if (track.errors == 0) begin
      $display("tb_stack_arithmetic_unit: clean");
    end else begin
      $display("tb_stack_arithmetic_unit: errors");
    end
    $finish;
  end

endmodule
